>>> rtl/core/pfc_pkg.sv
`default_nettype none
package pfc_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_KIND   = 3'd0,
    REG_TARGET_FORMAT = 3'd1,
    REG_ALPHA_MASK    = 3'd2,
    REG_RED_MASK      = 3'd3,
    REG_GREEN_MASK    = 3'd4,
    REG_BLUE_MASK     = 3'd5,
    REG_COLOUR_KEY    = 3'd6
  } cfg_idx_t;

  typedef enum logic [2:0] {
    FMT_RGB444   = 3'd0,
    FMT_ARGB4444 = 3'd1,
    FMT_RGB555   = 3'd2,
    FMT_RGB565   = 3'd3,
    FMT_ARGB1555 = 3'd4,
    FMT_RESERVED = 3'd5,
    FMT_RGB888   = 3'd6,
    FMT_ARGB8888 = 3'd7
  } fmt_t;

  typedef enum logic {
    SRC_BGR24    = 1'b0,
    SRC_BITFIELD = 1'b1
  } src_kind_t;

  localparam int unsigned PIXEL_W  = 32;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned COMP_W   = 8;
  localparam int unsigned NUM_COMP = 4;
  localparam int unsigned TZ_W     = 5;

  // Component slots: alpha, red, green, blue
  localparam int unsigned C_A = 0;
  localparam int unsigned C_R = 1;
  localparam int unsigned C_G = 2;
  localparam int unsigned C_B = 3;

  localparam logic [COMP_W-1:0] ALPHA_OPAQUE   = 8'hFF;
  localparam logic [KEY_W-1:0]  KEY_CLEAR_MASK = 16'h7FFF;

  typedef struct packed {
    logic [3:0] a;
    logic [3:0] r;
    logic [3:0] g;
    logic [3:0] b;
  } comp_widths_t;

  function automatic comp_widths_t fmt_widths(input fmt_t f);
    comp_widths_t w;
    unique case (f)
      FMT_RGB444:   w = '{a: 4'd0, r: 4'd4, g: 4'd4, b: 4'd4};
      FMT_ARGB4444: w = '{a: 4'd4, r: 4'd4, g: 4'd4, b: 4'd4};
      FMT_RGB555:   w = '{a: 4'd0, r: 4'd5, g: 4'd5, b: 4'd5};
      FMT_RGB565:   w = '{a: 4'd0, r: 4'd5, g: 4'd6, b: 4'd5};
      FMT_ARGB1555: w = '{a: 4'd1, r: 4'd5, g: 4'd5, b: 4'd5};
      FMT_RESERVED: w = '{a: 4'd0, r: 4'd0, g: 4'd0, b: 4'd0};
      FMT_RGB888:   w = '{a: 4'd0, r: 4'd8, g: 4'd8, b: 4'd8};
      FMT_ARGB8888: w = '{a: 4'd8, r: 4'd8, g: 4'd8, b: 4'd8};
      default:      w = '{a: 4'd0, r: 4'd0, g: 4'd0, b: 4'd0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/pfc_if.sv
`default_nettype none
interface pfc_pixel_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfc_pkg::PIXEL_W-1:0]   source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface pfc_pixel_out_if;
  logic                          valid;
  logic                          ready;
  logic [pfc_pkg::PIXEL_W-1:0]   display_pixel;
  logic                          pixel_written;

  modport source (output valid, output display_pixel, output pixel_written, input ready);
  modport sink   (input valid, input display_pixel, input pixel_written, output ready);
endinterface

interface pfc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfc_pkg::CFG_IDX_W-1:0]   index;
  logic [pfc_pkg::PIXEL_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/pixel_format_converter.sv
`default_nettype none
// Pixel format converter: one source pixel word in, one display pixel out.
//
// Channels
//   in_pix  : source pixel requests (valid/ready, source_pixel).
//   out_pix : display pixel requests (valid/ready, display_pixel, pixel_written).
//   cfg_wr  : register writes (valid/ready, index, data); always ready. Write
//             only while no pixel is in flight.
//
// Timing
//   Four register stages: mask and trailing-zero count, component extract,
//   reduce and pack, then keying into the output register. An accepted pixel
//   is registered in each stage in turn and then presented on out_pix. One pixel per cycle
//   is sustained while out_pix.ready stays high; each stage takes a request whenever it is empty or its
//   successor takes its contents, so bubbles are squeezed out while the sink
//   stalls.
//
// Reset (rst_n low, synchronous) empties every stage and sets the registers
// to BGR24 source, ARGB1555 target, zero masks and keying off. When the
// receiver stalls, the output register holds its pixel and the stages behind
// it fill up; in_pix.ready drops only once all four stages are occupied.
module pixel_format_converter (
  input  wire                  clk,
  input  wire                  rst_n,
  pfc_pixel_in_if.sink         in_pix,
  pfc_pixel_out_if.source      out_pix,
  pfc_cfg_if.sink              cfg_wr
);

  localparam int unsigned PW = pfc_pkg::PIXEL_W;
  localparam int unsigned CW = pfc_pkg::COMP_W;
  localparam int unsigned KW = pfc_pkg::KEY_W;
  localparam int unsigned NC = pfc_pkg::NUM_COMP;
  localparam int unsigned TW = pfc_pkg::TZ_W;
  localparam int unsigned RGB_W = 3 * CW;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  pfc_pkg::src_kind_t       source_kind_r;
  pfc_pkg::fmt_t            target_format_r;
  logic [PW-1:0]            mask_r [NC];
  logic [KW-1:0]            colour_key_r;

  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_kind_r   <= pfc_pkg::SRC_BGR24;
      target_format_r <= pfc_pkg::FMT_ARGB1555;
      for (int c = 0; c < NC; c++) begin
        mask_r[c] <= '0;
      end
      colour_key_r    <= '0;
    end else if (cfg_wr.valid) begin
      unique case (pfc_pkg::cfg_idx_t'(cfg_wr.index))
        pfc_pkg::REG_SOURCE_KIND:   source_kind_r   <= pfc_pkg::src_kind_t'(cfg_wr.data[0]);
        pfc_pkg::REG_TARGET_FORMAT: target_format_r <= pfc_pkg::fmt_t'(cfg_wr.data[2:0]);
        pfc_pkg::REG_ALPHA_MASK:    mask_r[pfc_pkg::C_A] <= cfg_wr.data;
        pfc_pkg::REG_RED_MASK:      mask_r[pfc_pkg::C_R] <= cfg_wr.data;
        pfc_pkg::REG_GREEN_MASK:    mask_r[pfc_pkg::C_G] <= cfg_wr.data;
        pfc_pkg::REG_BLUE_MASK:     mask_r[pfc_pkg::C_B] <= cfg_wr.data;
        pfc_pkg::REG_COLOUR_KEY:    colour_key_r    <= cfg_wr.data[KW-1:0];
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Trailing-zero count: isolate the lowest set bit, then encode it.
  // A zero mask gives 0 here; the masked word is zero anyway.
  function automatic logic [TW-1:0] tz_of(input logic [PW-1:0] m);
    logic [PW-1:0] lsb;
    logic [TW-1:0] n;
    lsb = m & (~m + PW'(1));
    n   = '0;
    for (int i = 0; i < PW; i++) begin
      if (lsb[i]) n = n | TW'(i);
    end
    return n;
  endfunction

  function automatic logic [CW-1:0] reduce(input logic [CW-1:0] v, input logic [3:0] w);
    logic [3:0] sh;
    sh = 4'd8 - w;
    return CW'({1'b0, v} >> sh);
  endfunction

  // ---------------------------------------------------------------------------
  // Stage handshake: a stage loads when empty or when its successor loads
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !out_v_r || out_pix.ready;
  assign rdy3 = !s3_v_r  || rdy4;
  assign rdy2 = !s2_v_r  || rdy3;
  assign rdy1 = !s1_v_r  || rdy2;

  assign in_pix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy1) s1_v_r  <= in_pix.valid;
      if (rdy2) s2_v_r  <= s1_v_r;
      if (rdy3) s3_v_r  <= s2_v_r;
      if (rdy4) out_v_r <= s3_v_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: apply masks, count trailing zeros of each mask
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    s1_masked_r [NC];
  logic [TW-1:0]    s1_tz_r     [NC];
  logic [RGB_W-1:0] s1_px_r;

  always_ff @(posedge clk) begin
    if (rdy1 && in_pix.valid) begin
      for (int c = 0; c < NC; c++) begin
        s1_masked_r[c] <= in_pix.source_pixel & mask_r[c];
        s1_tz_r[c]     <= tz_of(mask_r[c]);
      end
      s1_px_r <= in_pix.source_pixel[RGB_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: shift each masked component down (bitfield) or take the R, G, B bytes (BGR24), keep 8 bits
  // ---------------------------------------------------------------------------
  logic [CW-1:0]    s2_comp_r [NC];
  logic [RGB_W-1:0] s2_px_r;
  logic [CW-1:0]    s2_comp_nxt [NC];

  always_comb begin
    if (source_kind_r == pfc_pkg::SRC_BITFIELD) begin
      for (int c = 0; c < NC; c++) begin
        s2_comp_nxt[c] = CW'(s1_masked_r[c] >> s1_tz_r[c]);
      end
    end else begin
      s2_comp_nxt[pfc_pkg::C_A] = '0;
      s2_comp_nxt[pfc_pkg::C_R] = s1_px_r[3*CW-1:2*CW];
      s2_comp_nxt[pfc_pkg::C_G] = s1_px_r[2*CW-1:CW];
      s2_comp_nxt[pfc_pkg::C_B] = s1_px_r[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      for (int c = 0; c < NC; c++) begin
        s2_comp_r[c] <= s2_comp_nxt[c];
      end
      s2_px_r <= s1_px_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: reduce to target widths and pack B, G, R, A from the low end
  // ---------------------------------------------------------------------------
  logic [KW-1:0]        s3_p16_r;
  logic [RGB_W-1:0]     s3_px_r;
  logic [KW-1:0]        s3_p16_nxt;
  pfc_pkg::comp_widths_t wd;
  logic [4:0]           sh_g, sh_r, sh_a;
  logic [PW-1:0]        packed_w;
  logic [KW-1:0]        alpha_fill;

  always_comb begin
    wd   = pfc_pkg::fmt_widths(target_format_r);
    sh_g = 5'(wd.b);
    sh_r = sh_g + 5'(wd.g);
    sh_a = sh_r + 5'(wd.r);
    packed_w = PW'(reduce(s2_comp_r[pfc_pkg::C_B], wd.b))
             | (PW'(reduce(s2_comp_r[pfc_pkg::C_G], wd.g)) << sh_g)
             | (PW'(reduce(s2_comp_r[pfc_pkg::C_R], wd.r)) << sh_r)
             | (PW'(reduce(s2_comp_r[pfc_pkg::C_A], wd.a)) << sh_a);
    // BGR24 source: force the top alpha-width bits high
    alpha_fill = (source_kind_r == pfc_pkg::SRC_BGR24) ? ~({KW{1'b1}} >> wd.a) : '0;
    s3_p16_nxt = packed_w[KW-1:0] | alpha_fill;
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_p16_r <= s3_p16_nxt;
      s3_px_r  <= s2_px_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: colour key, 32-bit pass-through, reserved target; output register
  // ---------------------------------------------------------------------------
  logic [PW-1:0] out_pixel_r, out_pixel_nxt;
  logic          out_written_r, out_written_nxt;

  always_comb begin
    out_written_nxt = 1'b1;
    out_pixel_nxt   = PW'(s3_p16_r);
    if (colour_key_r != '0 && colour_key_r == s3_p16_r) begin
      out_pixel_nxt = PW'(s3_p16_r & pfc_pkg::KEY_CLEAR_MASK);
    end
    if (source_kind_r == pfc_pkg::SRC_BGR24) begin
      case (target_format_r) inside
        pfc_pkg::FMT_RESERVED: begin
          out_pixel_nxt   = '0;
          out_written_nxt = 1'b0;
        end
        pfc_pkg::FMT_RGB888, pfc_pkg::FMT_ARGB8888: begin
          out_pixel_nxt = {pfc_pkg::ALPHA_OPAQUE, s3_px_r};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4 && s3_v_r) begin
      out_pixel_r   <= out_pixel_nxt;
      out_written_r <= out_written_nxt;
    end
  end

  assign out_pix.valid         = out_v_r;
  assign out_pix.display_pixel = out_pixel_r;
  assign out_pix.pixel_written = out_written_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_pix.ready |=> out_v_r && $stable(out_pixel_r))
    else $error("output pixel lost or changed under stall");

  a_empty_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_v_r |-> in_pix.ready)
    else $error("input refused with empty first stage");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_written_r |-> out_pixel_r == '0)
    else $error("unwritten pixel carries data");

  a_upper_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_pixel_r[PW-1:KW] != '0 |->
      source_kind_r == pfc_pkg::SRC_BGR24 &&
      (target_format_r == pfc_pkg::FMT_RGB888 || target_format_r == pfc_pkg::FMT_ARGB8888))
    else $error("upper half set on a 16-bit result");

  a_key_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && colour_key_r[KW-1] && out_pixel_r[PW-1:KW] == '0 && out_written_r |->
      out_pixel_r[KW-1:0] != colour_key_r)
    else $error("colour key match not cleared");

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int unsigned PIPE_DEPTH   = 3;       // sizes the idle wait in settle()
  localparam int unsigned ITEMS_TOTAL  = 1650;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct packed {
    logic [31:0] pixel;
    logic        written;
  } pixel_result_t;

  // Own model of the converter: register copy, conversion and the queue of
  // display pixels still owed by the block.
  class conversion_check;
    pfc_pkg::src_kind_t kind;
    pfc_pkg::fmt_t      fmt;
    logic [31:0]   alpha_mask, red_mask, green_mask, blue_mask;
    logic [15:0]   colour_key;
    pixel_result_t owed_pixels[$];
    int unsigned   mismatches;
    int unsigned   checked;

    function new();
      kind       = pfc_pkg::SRC_BGR24;
      fmt        = pfc_pkg::FMT_ARGB1555;
      alpha_mask = '0;
      red_mask   = '0;
      green_mask = '0;
      blue_mask  = '0;
      colour_key = '0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void write_reg(pfc_pkg::cfg_idx_t idx, logic [31:0] v);
      case (idx)
        pfc_pkg::REG_SOURCE_KIND:   kind = pfc_pkg::src_kind_t'(v[0]);
        pfc_pkg::REG_TARGET_FORMAT: fmt = pfc_pkg::fmt_t'(v[2:0]);
        pfc_pkg::REG_ALPHA_MASK:    alpha_mask = v;
        pfc_pkg::REG_RED_MASK:      red_mask = v;
        pfc_pkg::REG_GREEN_MASK:    green_mask = v;
        pfc_pkg::REG_BLUE_MASK:     blue_mask = v;
        pfc_pkg::REG_COLOUR_KEY:    colour_key = v[15:0];
        default:                    ;
      endcase
    endfunction

    // Take a component through its mask, align it to bit 0, keep 8 bits.
    function logic [31:0] pick(logic [31:0] px, logic [31:0] m);
      int unsigned sh;
      if (m == '0) return '0;
      sh = 0;
      while (m[sh] == 1'b0) sh++;
      return ((px & m) >> sh) & 32'hFF;
    endfunction

    function logic [31:0] shrink(logic [31:0] v, int unsigned w);
      return (v & 32'hFF) >> (8 - w);
    endfunction

    function logic [31:0] keyed(logic [15:0] p16);
      if (colour_key != '0 && colour_key == p16) p16[15] = 1'b0;
      return {16'h0, p16};
    endfunction

    function pixel_result_t convert(logic [31:0] px);
      int unsigned   aw, rw, gw, bw;
      logic [31:0]   a, r, g, b, p;
      pixel_result_t res;
      res.pixel   = '0;
      res.written = 1'b1;
      case (fmt)
        pfc_pkg::FMT_RGB444:   begin aw = 0; rw = 4; gw = 4; bw = 4; end
        pfc_pkg::FMT_ARGB4444: begin aw = 4; rw = 4; gw = 4; bw = 4; end
        pfc_pkg::FMT_RGB555:   begin aw = 0; rw = 5; gw = 5; bw = 5; end
        pfc_pkg::FMT_RGB565:   begin aw = 0; rw = 5; gw = 6; bw = 5; end
        pfc_pkg::FMT_ARGB1555: begin aw = 1; rw = 5; gw = 5; bw = 5; end
        pfc_pkg::FMT_RGB888:   begin aw = 0; rw = 8; gw = 8; bw = 8; end
        pfc_pkg::FMT_ARGB8888: begin aw = 8; rw = 8; gw = 8; bw = 8; end
        default:               begin aw = 0; rw = 0; gw = 0; bw = 0; end
      endcase
      if (kind == pfc_pkg::SRC_BGR24) begin
        b = {24'h0, px[7:0]};
        g = {24'h0, px[15:8]};
        r = {24'h0, px[23:16]};
        if (fmt == pfc_pkg::FMT_RESERVED) begin
          res.written = 1'b0;
        end else if (fmt == pfc_pkg::FMT_RGB888 || fmt == pfc_pkg::FMT_ARGB8888) begin
          res.pixel = {8'hFF, px[23:0]};
        end else begin
          p = '0;
          for (int k = 0; k < aw; k++) p[15-k] = 1'b1;
          p |= shrink(b, bw) | (shrink(g, gw) << bw) | (shrink(r, rw) << (bw + gw));
          res.pixel = keyed(p[15:0]);
        end
      end else begin
        a = pick(px, alpha_mask);
        r = pick(px, red_mask);
        g = pick(px, green_mask);
        b = pick(px, blue_mask);
        p = shrink(b, bw) | (shrink(g, gw) << bw) | (shrink(r, rw) << (bw + gw))
          | (shrink(a, aw) << (bw + gw + rw));
        res.pixel = keyed(p[15:0]);
      end
      return res;
    endfunction

    function void note_source(logic [31:0] px);
      owed_pixels.push_back(convert(px));
    endfunction

    function void check_display(logic [31:0] dp, logic pw);
      pixel_result_t want;
      checked++;
      if (owed_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected display pixel %h written %b", dp, pw);
        return;
      end
      want = owed_pixels.pop_front();
      if (dp !== want.pixel || pw !== want.written) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: expected pixel %h written %b, got pixel %h written %b",
                   checked, want.pixel, want.written, dp, pw);
      end
    endfunction

    function int unsigned pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  pfc_pixel_in_if  in_pix();
  pfc_pixel_out_if out_pix();
  pfc_cfg_if       cfg_wr();

  pixel_format_converter dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix),
    .cfg_wr  (cfg_wr)
  );

  conversion_check sb;

  int unsigned cycles = 0;
  int unsigned requests = 0;        // source pixel requests accepted
  int unsigned settings_used = 0;   // register settings applied
  int unsigned holds_done = 0;
  bit          steady = 1'b0;       // no random idling on either side while set
  logic        hold_off;            // receiver holds ready low while set

  always #5 clk = ~clk;

  // Watchdog: end the run if it hangs anywhere.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Offer one source pixel; hold it until the block takes the request.
  // Valid stays high on return so that back-to-back requests carry no bubble.
  task automatic send_pixel(input logic [31:0] px);
    while (!steady && hold_off !== 1'b1 && $urandom_range(0, 99) < 20) begin
      in_pix.valid <= 1'b0;
      @(posedge clk);
    end
    in_pix.valid        <= 1'b1;
    in_pix.source_pixel <= px;
    @(posedge clk);
    while (in_pix.ready !== 1'b1) @(posedge clk);
    sb.note_source(px);
    requests++;
  endtask

  // One register write; valid is left high for the next write of a batch.
  task automatic put_reg(input pfc_pkg::cfg_idx_t idx, input logic [31:0] v);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= v;
    @(posedge clk);
    while (cfg_wr.ready !== 1'b1) @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  // Write the full register set, then drop the write request before returning,
  // so a following write cannot be folded into the same step.
  task automatic configure(input pfc_pkg::src_kind_t kind, input pfc_pkg::fmt_t fmt,
                           input logic [31:0] am, input logic [31:0] rm,
                           input logic [31:0] gm, input logic [31:0] bm,
                           input logic [15:0] key);
    put_reg(pfc_pkg::REG_SOURCE_KIND, {31'h0, kind});
    put_reg(pfc_pkg::REG_TARGET_FORMAT, {29'h0, fmt});
    put_reg(pfc_pkg::REG_ALPHA_MASK, am);
    put_reg(pfc_pkg::REG_RED_MASK, rm);
    put_reg(pfc_pkg::REG_GREEN_MASK, gm);
    put_reg(pfc_pkg::REG_BLUE_MASK, bm);
    put_reg(pfc_pkg::REG_COLOUR_KEY, {16'h0, key});
    cfg_wr.valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Drop the source request, wait for every owed pixel, then let the
  // pipeline run empty before the registers may change.
  task automatic settle();
    in_pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Contiguous fields at random places, plus empty, full, single-bit
  // and scattered masks.
  function automatic logic [31:0] random_mask();
    int unsigned w, pos;
    logic [63:0] m;
    case ($urandom_range(0, 5)) inside
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: begin
        w   = $urandom_range(1, 12);
        pos = $urandom_range(0, 32 - w);
        m   = ((64'd1 << w) - 64'd1) << pos;
        return m[31:0];
      end
      4: return $urandom;
      default: return 32'd1 << $urandom_range(0, 31);
    endcase
  endfunction

  // Receiver: check each accepted display pixel against the oldest owed one,
  // then pick the next ready. A hold-off forces ready low.
  initial begin
    out_pix.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_pix.valid === 1'b1 && out_pix.ready === 1'b1)
        sb.check_display(out_pix.display_pixel, out_pix.pixel_written);
      out_pix.ready <= (hold_off !== 1'b1) && (steady || $urandom_range(0, 99) >= 20);
    end
  end

  // Back-pressure: twice, hold the receiver off for a long stretch while the
  // sender keeps offering, so the stages fill and the input stalls.
  initial begin
    hold_off <= 1'b0;
    for (int h = 0; h < 2; h++) begin
      wait (requests >= 400 + 600 * h);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
      holds_done++;
    end
  end

  initial begin
    logic [31:0]        kp, px;
    pixel_result_t      probe;
    pfc_pkg::src_kind_t kind;
    pfc_pkg::fmt_t      fmt;
    bit                 hunt;
    int unsigned        n;

    sb = new();
    rst_n               <= 1'b0;
    in_pix.valid        <= 1'b0;
    in_pix.source_pixel <= '0;
    cfg_wr.valid        <= 1'b0;
    cfg_wr.index        <= pfc_pkg::REG_SOURCE_KIND;
    cfg_wr.data         <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: BGR24 into ARGB1555, keying off.
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    settle();

    // BGR24 into every target, reserved included; the second pixel carries
    // a set upper byte, which must be ignored.
    for (int f = 0; f < 8; f++) begin
      configure(pfc_pkg::SRC_BGR24, pfc_pkg::fmt_t'(f), '0, '0, '0, '0, '0);
      send_pixel(32'h005A_8F3C);
      send_pixel(32'hA5C3_0F87);
      settle();
    end

    // Colour key hit on an all-ones ARGB1555 pixel, then a near miss.
    configure(pfc_pkg::SRC_BGR24, pfc_pkg::FMT_ARGB1555, '0, '0, '0, '0, 16'hFFFF);
    send_pixel(32'h00FF_FFFF);
    send_pixel(32'hFFF7_FFFF);
    settle();

    // Bitfield into a 32-bit target: only B and G survive the 16-bit cut.
    configure(pfc_pkg::SRC_BITFIELD, pfc_pkg::FMT_ARGB8888, 32'hFF00_0000, 32'h00FF_0000,
              32'h0000_FF00, 32'h0000_00FF, '0);
    send_pixel(32'h80C0_E0F0);
    settle();

    // Empty masks, a full-width mask cut to 8 bits, a single top bit.
    configure(pfc_pkg::SRC_BITFIELD, pfc_pkg::FMT_RGB565, '0, 32'hFFFF_FFFF, '0,
              32'h8000_0000, '0);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'h1234_5678);
    settle();

    // Bitfield into the reserved target still writes a zero pixel.
    configure(pfc_pkg::SRC_BITFIELD, pfc_pkg::FMT_RESERVED, 32'hFF00_0000, 32'h00FF_0000,
              32'h0000_FF00, 32'h0000_00FF, '0);
    send_pixel(32'hFFFF_FFFF);
    settle();

    // Random settings, each followed by a burst of pixels. A few phases in
    // the middle run with no random idling.
    for (int ph = 0; requests < ITEMS_TOTAL; ph++) begin
      steady = (ph >= 6 && ph < 10);
      kind   = pfc_pkg::src_kind_t'($urandom_range(0, 1));
      fmt    = pfc_pkg::fmt_t'($urandom_range(0, 7));
      hunt   = ($urandom_range(0, 3) >= 2);
      configure(kind, fmt, random_mask(), random_mask(), random_mask(), random_mask(),
                hunt ? 16'h0 : 16'($urandom_range(0, 65535)));
      kp = $urandom;
      // Aim the key at a pixel that this phase will send again and again.
      if (hunt) begin
        probe = sb.convert(kp);
        if (probe.written && probe.pixel[31:16] == '0 && probe.pixel[15:0] != '0) begin
          put_reg(pfc_pkg::REG_COLOUR_KEY, probe.pixel);
          cfg_wr.valid <= 1'b0;
          @(posedge clk);
        end
      end
      n = $urandom_range(40, 64);
      repeat (n) begin
        case ($urandom_range(0, 15)) inside
          0, 1: px = kp;
          2: begin
            px = $urandom;
            px[23:0] = kp[23:0];
          end
          3: px = 32'h0000_0000;
          4: px = 32'hFFFF_FFFF;
          default: px = $urandom;
        endcase
        send_pixel(px);
      end
      settle();
    end
    steady = 1'b0;

    $display("%0d source pixel requests over %0d register settings, %0d results checked",
             requests, settings_used, sb.checked);
    $display("both source kinds, all targets, keyed pixels, %0d long receiver stalls, %0d mismatches",
             holds_done, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
